// ===== src/spq_pkg.sv =====
// shared types, constants and helpers for the sorted priority queue
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRI_WIDTH = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int PRI_FIELD_W = 8;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef logic [PRI_WIDTH-1:0] t_prio;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_prio                    prio;
    } t_entry;

    typedef struct packed {
        t_opcode                  opcode;
        logic signed [DATA_W-1:0] data_in;
        logic [PRI_FIELD_W-1:0]   priority_in;
    } t_in;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data_out;
        logic [PRI_FIELD_W-1:0]   priority_out;
        logic [CNT_W-1:0]         occupancy;
    } t_out;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry ins;
    } t_cell_ctl;

    // priority field to stored priority, upper bits masked off
    function automatic t_prio pri_from_field(input logic [PRI_FIELD_W-1:0] f);
        t_prio r;
        r = '0;
        for (int b = 0; b < PRI_WIDTH; b++) begin
            if (b < PRI_FIELD_W) begin
                r[b] = f[b];
            end
        end
        return r;
    endfunction

    // stored priority back to the field width
    function automatic logic [PRI_FIELD_W-1:0] pri_to_field(input t_prio p);
        logic [PRI_FIELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < PRI_FIELD_W; b++) begin
            if (b < PRI_WIDTH) begin
                r[b] = p[b];
            end
        end
        return r;
    endfunction

endpackage

// ===== src/spq_cell.sv =====
// one slot of the sorted register chain
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_prev_entry,
    input  logic               i_prev_after,
    input  spq_pkg::t_entry    i_next_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_after
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // new entry lands at or before this slot
    assign o_after = !(i_occ && (r_entry.prio <= i_ctl.ins.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq && o_after) begin
            n_entry = i_prev_after ? i_prev_entry : i_ctl.ins;
        end else if (i_ctl.deq) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== src/sorted_priority_queue.sv =====
// sorted priority queue built as a chain of register cells
//
//   channel   valid        ready        payload
//   input     i_in_valid   o_in_ready   i_in_data  (opcode, data_in, priority_in)
//   output    o_out_valid  i_out_ready  o_out_data (status, data_out, priority_out, occupancy)
//
// every cell compares against the new priority in parallel and shifts toward
// the back (enqueue) or the front (dequeue) in the same cycle. the result sits
// in an output register; a new transaction is taken whenever that register is
// empty or being drained. reset clears the occupancy count and the output
// valid; cell contents are not reset.
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_out o_out_data
);

    localparam int D = spq_pkg::DEPTH;

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_out_valid;
    spq_pkg::t_out             r_out;
    spq_pkg::t_out             w_res;
    spq_pkg::t_cell_ctl        w_ctl;
    logic                      w_take;
    logic                      w_full;
    logic                      w_empty;

    spq_pkg::t_entry w_entry      [D];
    logic            w_after      [D];
    spq_pkg::t_entry w_prev_entry [D];
    logic            w_prev_after [D];
    spq_pkg::t_entry w_next_entry [D];
    logic            w_occ        [D];

    // output register frees up when empty or drained this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_full  = (r_count == spq_pkg::CNT_W'(D));
    assign w_empty = (r_count == '0);

    // decode the operation, build the cell command and the result
    always_comb begin
        w_ctl.enq          = 1'b0;
        w_ctl.deq          = 1'b0;
        w_ctl.ins.data     = i_in_data.data_in;
        w_ctl.ins.prio     = spq_pkg::pri_from_field(i_in_data.priority_in);
        n_count            = r_count;
        w_res.status       = spq_pkg::ST_OK;
        w_res.data_out     = '0;
        w_res.priority_out = '0;
        case (i_in_data.opcode)
            spq_pkg::OP_ENQ: begin
                if (w_full) begin
                    w_res.status = spq_pkg::ST_OVER;
                end else begin
                    w_ctl.enq = w_take;
                    n_count   = r_count + 1'b1;
                end
            end
            spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
                if (w_empty) begin
                    w_res.status = spq_pkg::ST_UNDER;
                end else begin
                    w_res.data_out     = w_entry[0].data;
                    w_res.priority_out = spq_pkg::pri_to_field(w_entry[0].prio);
                    if (i_in_data.opcode == spq_pkg::OP_DEQ) begin
                        w_ctl.deq = w_take;
                        n_count   = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // unused code: no operation, report current count
            end
        endcase
        w_res.occupancy = n_count;
    end

    // cell chain with neighbor links; front is cell 0
    for (genvar g = 0; g < D; g++) begin : g_cell
        assign w_occ[g] = (spq_pkg::CNT_W'(g) < r_count);

        if (g == 0) begin : g_front
            assign w_prev_entry[g] = '0;
            assign w_prev_after[g] = 1'b0;
        end else begin : g_mid
            assign w_prev_entry[g] = w_entry[g-1];
            assign w_prev_after[g] = w_after[g-1];
        end

        if (g == D - 1) begin : g_back
            assign w_next_entry[g] = '0;
        end else begin : g_inner
            assign w_next_entry[g] = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (w_occ[g]),
            .i_prev_entry (w_prev_entry[g]),
            .i_prev_after (w_prev_after[g]),
            .i_next_entry (w_next_entry[g]),
            .o_entry      (w_entry[g]),
            .o_after      (w_after[g])
        );
    end

    // occupancy count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
// self-checking testbench for the sorted priority queue
module tb_sorted_priority_queue;

    // opcode 3 is not a package member; the block treats it as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int STALL_LIMIT = 4000;  // cycles without any transaction
    localparam int TAIL_CYCLES = 20;    // settle time once nothing is expected
    localparam int HOLDOFF_LEN = 300;   // long receiver hold-off

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_ready;
    spq_pkg::t_in   i_in_data = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    spq_pkg::t_out  o_out_data;

    sorted_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    spq_pkg::t_in    pending_ops[$];        // operations still to be offered
    spq_pkg::t_out   expected_results[$];   // predicted results in order
    spq_pkg::t_entry model_entries[$];      // predicted queue contents, front first

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int holdoff_req = 0;
    int holdoff_ack = 0;
    int holdoff_cnt = 0;
    int mismatch_count = 0;
    int result_index = 0;
    int quiet_cycles = 0;

    // applies one operation to the model queue and returns the result
    function automatic spq_pkg::t_out predict_queue_op(input spq_pkg::t_in op);
        spq_pkg::t_out   res;
        spq_pkg::t_entry ent;
        int              pos;
        res = '0;
        res.status = spq_pkg::ST_OK;
        case (op.opcode)
            spq_pkg::OP_ENQ: begin
                if (model_entries.size() >= spq_pkg::DEPTH) begin
                    res.status = spq_pkg::ST_OVER;
                end else begin
                    ent.data = op.data_in;
                    ent.prio = spq_pkg::t_prio'(op.priority_in);
                    // behind every entry of equal or smaller priority
                    pos = 0;
                    while (pos < model_entries.size() && model_entries[pos].prio <= ent.prio)
                        pos++;
                    model_entries.insert(pos, ent);
                end
            end
            spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
                if (model_entries.size() == 0) begin
                    res.status = spq_pkg::ST_UNDER;
                end else begin
                    res.data_out = model_entries[0].data;
                    res.priority_out = model_entries[0].prio;
                    if (op.opcode == spq_pkg::OP_DEQ)
                        void'(model_entries.pop_front());
                end
            end
            default: begin
            end
        endcase
        res.occupancy = spq_pkg::CNT_W'(model_entries.size());
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatch_count < 200)
            $display("mismatch on result %0d, %s: got %0d expected %0d",
                     result_index, field, got, want);
        mismatch_count++;
    endtask

    task automatic queue_op(input logic [1:0] code, input logic signed [31:0] data,
                            input logic [7:0] prio);
        spq_pkg::t_in op;
        op.opcode = spq_pkg::t_opcode'(code);
        op.data_in = data;
        op.priority_in = prio;
        pending_ops.push_back(op);
    endtask

    // random operations in stretches that lean toward filling or draining,
    // so the queue keeps passing through empty and full
    task automatic push_random(input int n);
        int enq_pct;
        int left_in_run;
        int r;
        logic [1:0] code;
        logic signed [31:0] data;
        logic [7:0] prio;
        enq_pct = 65;
        left_in_run = 0;
        for (int k = 0; k < n; k++) begin
            if (left_in_run == 0) begin
                enq_pct = (enq_pct > 50) ? 25 : 65;
                left_in_run = $urandom_range(10, 50);
            end
            left_in_run--;
            r = $urandom_range(99);
            if (r < 3)
                code = OP_NOP;
            else if (r < 3 + enq_pct)
                code = spq_pkg::OP_ENQ;
            else if (r % 4 == 0)
                code = spq_pkg::OP_PEEK;
            else
                code = spq_pkg::OP_DEQ;
            // narrow priority range gives plenty of ties
            prio = ($urandom_range(1) == 1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
            case ($urandom_range(15))
                0:       data = 32'sh8000_0000;
                1:       data = 32'sh7fff_ffff;
                default: data = $urandom();
            endcase
            queue_op(code, data, prio);
        end
    endtask

    // sender holds back until every offered transaction has its result
    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver: valid stays up until the transaction is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(predict_queue_op(i_in_data));
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_ops.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each result and drives ready
    always @(posedge i_clk) begin : monitor
        spq_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_out_data.status, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", o_out_data.status, want.status);
                    if (o_out_data.data_out !== want.data_out)
                        report_mismatch("data_out", o_out_data.data_out, want.data_out);
                    if (o_out_data.priority_out !== want.priority_out)
                        report_mismatch("priority_out", o_out_data.priority_out,
                                        want.priority_out);
                    if (o_out_data.occupancy !== want.occupancy)
                        report_mismatch("occupancy", o_out_data.occupancy, want.occupancy);
                end
                result_index <= result_index + 1;
            end
            // a new hold-off request overrides random stalling
            if (holdoff_req != holdoff_ack) begin
                holdoff_ack <= holdoff_req;
                holdoff_cnt <= HOLDOFF_LEN;
                i_out_ready <= 1'b0;
            end else if (holdoff_cnt > 0) begin
                holdoff_cnt <= holdoff_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue: underflow on dequeue and peek, no-op
        queue_op(spq_pkg::OP_DEQ, 32'sd5, 8'd1);
        queue_op(spq_pkg::OP_PEEK, 32'sd6, 8'd2);
        queue_op(OP_NOP, 32'sd7, 8'd3);
        // fill to capacity with extremes and ties
        queue_op(spq_pkg::OP_ENQ, 32'sd100, 8'd5);
        queue_op(spq_pkg::OP_ENQ, 32'sh8000_0000, 8'd255);
        queue_op(spq_pkg::OP_ENQ, 32'sh7fff_ffff, 8'd0);
        queue_op(spq_pkg::OP_ENQ, 32'sd1, 8'd5);
        queue_op(spq_pkg::OP_ENQ, 32'sd2, 8'd5);
        queue_op(spq_pkg::OP_ENQ, 32'sd3, 8'd0);
        queue_op(spq_pkg::OP_ENQ, 32'sd4, 8'd255);
        queue_op(spq_pkg::OP_ENQ, 32'sd5, 8'd128);
        queue_op(spq_pkg::OP_ENQ, 32'sd6, 8'd7);
        queue_op(spq_pkg::OP_ENQ, 32'sd7, 8'd5);
        queue_op(spq_pkg::OP_ENQ, 32'sd8, 8'd1);
        queue_op(spq_pkg::OP_ENQ, 32'sd9, 8'd254);
        queue_op(spq_pkg::OP_ENQ, 32'sd10, 8'd0);
        queue_op(spq_pkg::OP_ENQ, 32'sd11, 8'd128);
        queue_op(spq_pkg::OP_ENQ, 32'sd12, 8'd3);
        queue_op(spq_pkg::OP_ENQ, -32'sd1, 8'd5);
        // full queue: overflow drop, no-op, then peek and dequeue
        queue_op(spq_pkg::OP_ENQ, 32'sd99, 8'd0);
        queue_op(OP_NOP, 32'sd0, 8'd0);
        queue_op(spq_pkg::OP_PEEK, 32'sd0, 8'd0);
        queue_op(spq_pkg::OP_DEQ, 32'sd0, 8'd0);
        queue_op(spq_pkg::OP_ENQ, 32'sd42, 8'd0);
        queue_op(spq_pkg::OP_PEEK, 32'sd0, 8'd0);
        wait_drained();

        push_random(500);
        wait_drained();

        send_idle_pct = 84;
        push_random(500);
        wait_drained();

        send_idle_pct = 0;
        out_stall_pct = 84;
        push_random(500);
        wait_drained();

        send_idle_pct = 12;
        out_stall_pct = 12;
        push_random(400);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        out_stall_pct = 0;
        holdoff_req = holdoff_req + 1;
        push_random(40);
        wait_drained();

        push_random(120);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
